/* hw/rtl/ilp_pkg.sv */
// ----------------------------------------------------------------------------
// Integer literal parser package
// Character codes, radix and scan-position types, and digit decoding that are
// shared by the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  // Width of the result value on the output stream
  localparam int ValueW = 64;
  // Width of one input character
  localparam int CharW  = 8;
  // Width of a decoded digit (0..15, 16 means "not a digit")
  localparam int DigitW = 5;

  // Radix selection
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } radix_t;

  // Scan position within the token
  typedef enum logic [1:0] {
    POS_START  = 2'd0,  // token start
    POS_SIGN   = 2'd1,  // after the outer sign
    POS_PREFIX = 2'd2,  // after '&' or a leading '0'
    POS_BODY   = 2'd3   // inside the digit body
  } pos_t;

  // Character codes
  localparam logic [CharW-1:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [CharW-1:0] CH_MINUS   = 8'h2D;  // '-'
  localparam logic [CharW-1:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [CharW-1:0] CH_AMP     = 8'h26;  // '&'
  localparam logic [CharW-1:0] CH_0       = 8'h30;  // '0'
  localparam logic [CharW-1:0] CH_9       = 8'h39;  // '9'
  localparam logic [CharW-1:0] CH_A_UP    = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CH_F_UP    = 8'h46;  // 'F'
  localparam logic [CharW-1:0] CH_A_LO    = 8'h61;  // 'a'
  localparam logic [CharW-1:0] CH_F_LO    = 8'h66;  // 'f'
  localparam logic [CharW-1:0] CH_H_UP    = 8'h48;  // 'H'
  localparam logic [CharW-1:0] CH_H_LO    = 8'h68;  // 'h'
  localparam logic [CharW-1:0] CH_B_UP    = 8'h42;  // 'B'
  localparam logic [CharW-1:0] CH_B_LO    = 8'h62;  // 'b'
  localparam logic [CharW-1:0] CH_X_UP    = 8'h58;  // 'X'
  localparam logic [CharW-1:0] CH_X_LO    = 8'h78;  // 'x'

  // Radix values
  localparam logic [DigitW-1:0] RADIX_VAL_DEC = 5'd10;
  localparam logic [DigitW-1:0] RADIX_VAL_HEX = 5'd16;
  localparam logic [DigitW-1:0] RADIX_VAL_BIN = 5'd2;
  localparam logic [DigitW-1:0] DIGIT_NONE    = 5'd16;

  // Decode a character into a hex digit value, DIGIT_NONE if it is none
  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = DigitW'(c - CH_0);
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      d = DigitW'(c - CH_A_LO) + 5'd10;
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      d = DigitW'(c - CH_A_UP) + 5'd10;
    end
    return d;
  endfunction

endpackage

/* hw/rtl/integer_literal_parser_unit.sv */
// ----------------------------------------------------------------------------
// Integer literal parser unit
// Path: input beat to result beat via the input register, finished token
//   register and output register; only a beat with tlast set yields a result.
// Throughput: one character beat per cycle; a last beat waits for a free
//   finished token register. Scan: constant-radix multiply-add, range compare.
// Reset: synchronous, active low; clears all pipeline valids and scan state.
// ----------------------------------------------------------------------------
module integer_literal_parser_unit #(
  parameter int VALUE_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input character stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ilp_pkg::CharW-1:0]  in_tdata,   // [7:0] ch
  input  logic                       in_tlast,   // last
  // Result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ilp_pkg::ValueW-1:0] out_tdata,  // [63:0] value
  output logic                       out_tuser   // [0] valid_res
);
  import ilp_pkg::*;

  localparam int PW = VALUE_BITS + 4;
  localparam logic [PW-1:0] LimitPos = {5'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] MagMax = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Input register
  logic                  s1_valid_r;
  logic [CharW-1:0]      s1_ch_r;
  logic                  s1_last_r;

  // Scan state
  logic                  outer_r,  outer_nxt;
  logic                  inner_r,  inner_nxt;
  radix_t                radix_r,  radix_nxt;
  pos_t                  pos_r,    pos_nxt;
  logic                  digits_r, digits_nxt;
  logic [VALUE_BITS-1:0] mag_r,    mag_nxt;
  logic                  failed_r, failed_nxt;

  // Finished token register
  logic                  s2_valid_r;
  logic                  s2_ok_r,  s2_ok_nxt;
  logic                  s2_neg_r, s2_neg_nxt;
  logic [VALUE_BITS-1:0] s2_mag_r;

  // Output register
  logic                  out_tvalid_r;
  logic [ValueW-1:0]     out_tdata_r, out_tdata_nxt;
  logic                  out_tuser_r;

  // Handshake
  logic s1_ready, s1_fire, s2_ready, s3_ready;

  // Body character evaluation
  logic [DigitW-1:0]     radix_val;
  logic [DigitW-1:0]     dig;
  logic [PW-1:0]         mag_ext, prod, acc, limit;
  logic                  body_minus, body_bad, use_body, take_char;

  logic signed [VALUE_BITS-1:0] val_s;

  // Stage readiness, ready flows backward
  assign s3_ready  = !out_tvalid_r || out_tready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || s2_ready);
  assign s1_ready  = !s1_valid_r || s1_fire;
  assign in_tready = s1_ready;

  // Evaluate the character as a body digit against the current state
  always_comb begin
    case (radix_r)
      RADIX_HEX: radix_val = RADIX_VAL_HEX;
      RADIX_BIN: radix_val = RADIX_VAL_BIN;
      default:   radix_val = RADIX_VAL_DEC;
    endcase
    dig     = digit_of(s1_ch_r);
    mag_ext = PW'(mag_r);
    case (radix_r)
      RADIX_HEX: prod = mag_ext << 4;
      RADIX_BIN: prod = mag_ext << 1;
      default:   prod = (mag_ext << 3) + (mag_ext << 1);
    endcase
    acc        = prod + PW'(dig);
    limit      = LimitPos + PW'(inner_r);
    body_minus = (s1_ch_r == CH_MINUS) && !digits_r && !inner_r;
    body_bad   = (dig >= radix_val) || (acc > limit);
  end

  // Next scan state
  always_comb begin
    outer_nxt  = outer_r;
    inner_nxt  = inner_r;
    radix_nxt  = radix_r;
    pos_nxt    = pos_r;
    digits_nxt = digits_r;
    mag_nxt    = mag_r;
    failed_nxt = failed_r;
    use_body   = 1'b0;
    // Drop a trailing type suffix
    take_char  = !(s1_last_r && (s1_ch_r inside {CH_PERCENT, CH_AMP}));
    if (take_char) begin
      case (pos_r)
        POS_START, POS_SIGN: begin
          if (pos_r == POS_START && (s1_ch_r inside {CH_PLUS, CH_MINUS})) begin
            outer_nxt = (s1_ch_r == CH_MINUS);
            pos_nxt   = POS_SIGN;
          end else if (s1_ch_r == CH_AMP) begin
            digits_nxt = 1'b0;
            pos_nxt    = POS_PREFIX;
          end else if (s1_ch_r == CH_0) begin
            mag_nxt    = '0;
            digits_nxt = 1'b1;
            pos_nxt    = POS_PREFIX;
          end else begin
            use_body = 1'b1;
          end
        end
        POS_PREFIX: begin
          pos_nxt = POS_BODY;
          if (!digits_r) begin
            // After '&' only H or B may follow
            if (s1_ch_r inside {CH_H_UP, CH_H_LO}) begin
              radix_nxt = RADIX_HEX;
            end else if (s1_ch_r inside {CH_B_UP, CH_B_LO}) begin
              radix_nxt = RADIX_BIN;
            end else begin
              failed_nxt = 1'b1;
            end
          end else if (s1_ch_r inside {CH_X_UP, CH_X_LO}) begin
            radix_nxt  = RADIX_HEX;
            digits_nxt = 1'b0;
          end else if (s1_ch_r inside {CH_B_UP, CH_B_LO}) begin
            radix_nxt  = RADIX_BIN;
            digits_nxt = 1'b0;
          end else begin
            use_body = 1'b1;
          end
        end
        default: begin
          use_body = 1'b1;
        end
      endcase
    end
    // Apply a body character: inner sign, reject, or accumulate
    if (use_body) begin
      pos_nxt = POS_BODY;
      if (body_minus) begin
        inner_nxt = 1'b1;
      end else if (body_bad) begin
        failed_nxt = 1'b1;
      end else begin
        mag_nxt    = acc[VALUE_BITS-1:0];
        digits_nxt = 1'b1;
      end
    end
  end

  // Token outcome from the updated state
  always_comb begin
    s2_ok_nxt  = !failed_nxt && digits_nxt;
    s2_neg_nxt = inner_nxt ^ outer_nxt;
  end

  // Input register: hold until the scan stage takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
    if (s1_ready && in_tvalid) begin
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Scan state: advance per character, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      outer_r  <= 1'b0;
      inner_r  <= 1'b0;
      radix_r  <= RADIX_DEC;
      pos_r    <= POS_START;
      digits_r <= 1'b0;
      mag_r    <= '0;
      failed_r <= 1'b0;
    end else if (s1_fire) begin
      outer_r  <= outer_nxt;
      inner_r  <= inner_nxt;
      radix_r  <= radix_nxt;
      pos_r    <= pos_nxt;
      digits_r <= digits_nxt;
      mag_r    <= mag_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Finished token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_fire && s1_last_r;
    end
    if (s1_fire && s1_last_r) begin
      s2_ok_r  <= s2_ok_nxt;
      s2_neg_r <= s2_neg_nxt;
      s2_mag_r <= mag_nxt;
    end
  end

  // Apply the sign, wrap and sign-extend to the output width
  always_comb begin
    val_s         = s2_neg_r ? -$signed(s2_mag_r) : $signed(s2_mag_r);
    out_tdata_nxt = s2_ok_r ? ValueW'(val_s) : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s3_ready) begin
      out_tvalid_r <= s2_valid_r;
    end
    if (s3_ready && s2_valid_r) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= s2_ok_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // An invalid token always reports zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("invalid result carries a nonzero value");

  // Result is sign-extended from the value width
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[ValueW-1:VALUE_BITS-1] == '0) ||
                    (out_tdata[ValueW-1:VALUE_BITS-1] == '1)))
    else $error("result is not sign-extended");

  // Scan state is cleared after the last character of a token
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (pos_r == POS_START && !failed_r && !digits_r &&
                                mag_r == '0))
    else $error("scan state not cleared after token end");

  // Magnitude never leaves the signed range
  assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= MagMax)
    else $error("magnitude exceeds the value range");

endmodule
